FILE: hw/rtl/fwt_pkg.sv
`timescale 1ns / 1ps
// Shared constants, operation codes and unit interface types for the Fenwick tree block.
// Used by fwt_alu, fenwick_tree_order_statistic and its testbench; has no dependencies.
package fwt_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int VAL_W        = 32;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);

    localparam logic [2:0] OP_FILL = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_PSUM = 3'd2;
    localparam logic [2:0] OP_RSUM = 3'd3;
    localparam logic [2:0] OP_FIND = 3'd4;

    localparam logic [1:0] ALU_ADD   = 2'd0;
    localparam logic [1:0] ALU_SUB   = 2'd1;
    localparam logic [1:0] ALU_SCALE = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [VAL_W-1:0] lhs;
        logic [VAL_W-1:0] rhs;
        logic [VAL_W-1:0] limit;
    } alu_req_t;

    typedef struct packed {
        logic [VAL_W-1:0] result;
        logic             fits;
    } alu_rsp_t;

endpackage

FILE: hw/rtl/fwt_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module fwt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/fwt_alu.sv
`timescale 1ns / 1ps
// Shared arithmetic unit: add, subtract, scale by a node span, and signed limit compare.
// Depends on fwt_pkg.
module fwt_alu
    import fwt_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [VAL_W+CNT_W-1:0] prod;
    logic [VAL_W-1:0]       res;

    always_comb begin
        prod = req.lhs * req.rhs[CNT_W-1:0];
        case (req.op)
            ALU_ADD:   res = req.lhs + req.rhs;
            ALU_SUB:   res = req.lhs - req.rhs;
            ALU_SCALE: res = prod[VAL_W-1:0];
            default:   res = req.lhs;
        endcase
        rsp.result = res;
        rsp.fits   = !($signed(req.limit) < $signed(res));
    end

endmodule

FILE: hw/rtl/fenwick_tree_order_statistic.sv
`timescale 1ns / 1ps
// Top level of the Fenwick tree block: sequencer, configuration and stream ports.
// Depends on fwt_pkg, fwt_ram and fwt_alu.

// The block keeps a binary indexed tree of 1024 signed 32-bit nodes in one RAM with a
// registered read port, and runs one operation at a time under a small sequencer that
// drives a single shared add/compare unit. After reset a clearing pass writes all 1024
// nodes to zero, during which no word is accepted; configuration writes are taken at any
// time. A fill writes one node per cycle. An add reads and then writes each node visited
// (at most 11). A prefix sum reads and accumulates one node per set bit of the clamped
// count, and a range sum does this for both bounds. A find walks 11 span steps, reading
// and then comparing for each probe inside the size and only reading otherwise. Each word
// is accepted only in the idle state, and its result goes to the output register, which
// waits while an earlier result is still held there.
module fenwick_tree_order_statistic
    import fwt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data,      // size_in_use
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,       // index_a, index_b, operand_value, zero fill
    input  logic [2:0]  s_tuser,       // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,       // sum_result, found_count, zero fill
    output logic [0:0]  m_tuser        // op_done
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_FILL     = 4'd1;
    localparam logic [3:0] ST_ADD_RD   = 4'd2;
    localparam logic [3:0] ST_ADD_WR   = 4'd3;
    localparam logic [3:0] ST_SUM_RD   = 4'd4;
    localparam logic [3:0] ST_SUM_ACC  = 4'd5;
    localparam logic [3:0] ST_FIND_RD  = 4'd6;
    localparam logic [3:0] ST_FIND_CMP = 4'd7;
    localparam logic [3:0] ST_OUT      = 4'd8;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);

    logic [3:0]       state_reg, state_next;
    logic [2:0]       op_reg, op_next;
    logic [CNT_W-1:0] a_reg, a_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] at_reg, at_next;
    logic [VAL_W-1:0] acc_reg, acc_next;
    logic             phase_reg, phase_next;
    logic             clr_reg, clr_next;
    logic [CNT_W-1:0] size_reg, size_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [VAL_W-1:0] m_sum_reg, m_sum_next;
    logic [CNT_W-1:0] m_found_reg, m_found_next;
    logic             m_done_reg, m_done_next;

    logic [CNT_W-1:0] s_index_a;
    logic [CNT_W-1:0] s_index_b;
    logic [VAL_W-1:0] s_operand;
    logic [CNT_W-1:0] size_eff;
    logic [CNT_W-1:0] fill_end;
    logic [CNT_W-1:0] idx_p1;
    logic [CNT_W-1:0] span;
    logic [CNT_W:0]   probe;
    logic [CNT_W:0]   probe_m1;
    logic [CNT_W-1:0] idx_m1;
    logic             out_load;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    logic [VAL_W-1:0] ram_rdata;
    alu_req_t         alu_req;
    alu_rsp_t         alu_rsp;

    assign s_index_a = s_tdata[10:0];
    assign s_index_b = s_tdata[21:11];
    assign s_operand = s_tdata[53:22];

    assign size_eff = (size_reg > MAX_CNT) ? MAX_CNT : size_reg;
    assign fill_end = clr_reg ? MAX_CNT : size_eff;
    assign idx_p1   = idx_reg + CNT_W'(1);
    assign span     = idx_p1 & (~idx_p1 + CNT_W'(1));
    assign idx_m1   = idx_reg - CNT_W'(1);
    assign probe    = {1'b0, at_reg} + {1'b0, len_reg};
    assign probe_m1 = probe - (CNT_W+1)'(1);
    assign out_load = !m_tvalid_reg || m_tready;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {5'd0, m_found_reg, m_sum_reg};
    assign m_tuser   = m_done_reg;

    fwt_ram #(
        .WIDTH(VAL_W),
        .DEPTH(MAX_ELEMENTS)
    ) u_nodes (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(alu_rsp.result),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    fwt_alu u_alu (
        .req(alu_req),
        .rsp(alu_rsp)
    );

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        a_next        = a_reg;
        val_next      = val_reg;
        idx_next      = idx_reg;
        len_next      = len_reg;
        at_next       = at_reg;
        acc_next      = acc_reg;
        phase_next    = phase_reg;
        clr_next      = clr_reg;
        size_next     = size_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_sum_next    = m_sum_reg;
        m_found_next  = m_found_reg;
        m_done_next   = m_done_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg[IDX_W-1:0];
        ram_raddr     = idx_reg[IDX_W-1:0];
        alu_req.op    = ALU_ADD;
        alu_req.lhs   = acc_reg;
        alu_req.rhs   = ram_rdata;
        alu_req.limit = val_reg;

        if (cfg_valid) begin
            size_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    a_next     = (s_index_a > size_eff) ? size_eff : s_index_a;
                    val_next   = s_operand;
                    acc_next   = '0;
                    at_next    = '0;
                    len_next   = MAX_CNT;
                    phase_next = 1'b0;
                    case (s_tuser)
                        OP_FILL: begin
                            idx_next   = '0;
                            state_next = ST_FILL;
                        end
                        OP_ADD: begin
                            idx_next   = s_index_a;
                            state_next = ST_ADD_RD;
                        end
                        OP_PSUM: begin
                            idx_next   = (s_index_a > size_eff) ? size_eff : s_index_a;
                            state_next = ST_SUM_RD;
                        end
                        OP_RSUM: begin
                            idx_next   = (s_index_b > size_eff) ? size_eff : s_index_b;
                            state_next = ST_SUM_RD;
                        end
                        OP_FIND: begin
                            state_next = ST_FIND_RD;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_FILL: begin
                alu_req.op  = ALU_SCALE;
                alu_req.lhs = clr_reg ? '0 : val_reg;
                alu_req.rhs = VAL_W'(span);
                if (idx_reg < fill_end) begin
                    ram_we   = 1'b1;
                    idx_next = idx_p1;
                end else begin
                    state_next = clr_reg ? ST_IDLE : ST_OUT;
                    clr_next   = 1'b0;
                end
            end
            ST_ADD_RD: begin
                state_next = (idx_reg < size_eff) ? ST_ADD_WR : ST_OUT;
            end
            ST_ADD_WR: begin
                alu_req.lhs = ram_rdata;
                alu_req.rhs = val_reg;
                ram_we      = 1'b1;
                idx_next    = idx_reg | idx_p1;
                state_next  = ST_ADD_RD;
            end
            ST_SUM_RD: begin
                ram_raddr = idx_m1[IDX_W-1:0];
                if (idx_reg != '0) begin
                    state_next = ST_SUM_ACC;
                end else if (op_reg == OP_RSUM && !phase_reg) begin
                    idx_next   = a_reg;
                    phase_next = 1'b1;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_SUM_ACC: begin
                alu_req.op = phase_reg ? ALU_SUB : ALU_ADD;
                acc_next   = alu_rsp.result;
                idx_next   = idx_reg & idx_m1;
                state_next = ST_SUM_RD;
            end
            ST_FIND_RD: begin
                ram_raddr = probe_m1[IDX_W-1:0];
                if (len_reg == '0) begin
                    state_next = ST_OUT;
                end else if (probe <= {1'b0, size_eff}) begin
                    state_next = ST_FIND_CMP;
                end else begin
                    len_next = len_reg >> 1;
                end
            end
            ST_FIND_CMP: begin
                if (alu_rsp.fits) begin
                    acc_next = alu_rsp.result;
                    at_next  = probe[CNT_W-1:0];
                end
                len_next   = len_reg >> 1;
                state_next = ST_FIND_RD;
            end
            ST_OUT: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_sum_next    = (op_reg == OP_PSUM || op_reg == OP_RSUM) ? acc_reg : '0;
                    m_found_next  = (op_reg == OP_FIND) ? at_reg : '0;
                    m_done_next   = (op_reg <= OP_FIND);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_FILL;
            idx_reg      <= '0;
            clr_reg      <= 1'b1;
            phase_reg    <= 1'b0;
            size_reg     <= MAX_CNT;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            clr_reg      <= clr_next;
            phase_reg    <= phase_next;
            size_reg     <= size_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        a_reg       <= a_next;
        val_reg     <= val_next;
        len_reg     <= len_next;
        at_reg      <= at_next;
        acc_reg     <= acc_next;
        m_sum_reg   <= m_sum_next;
        m_found_reg <= m_found_next;
        m_done_reg  <= m_done_next;
    end

    // No word is accepted straight after another, since every operation is sequenced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an operation was in progress");

    // An accumulate step only follows a read of a real node.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM_ACC) |-> ($past(state_reg) == ST_SUM_RD && idx_reg != '0))
        else $error("prefix accumulate without a preceding node read");

    // A result for an unknown opcode carries all-zero data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == 1'b0) |-> (m_tdata == '0))
        else $error("unknown opcode produced nonzero result data");

endmodule

FILE: test/tb_fenwick_tree_order_statistic.sv
`timescale 1ns / 1ps
// Self-checking testbench for fenwick_tree_order_statistic: directed and random words with
// random stalls on both stream sides, checked against a behavioral tree model.
// Depends on fwt_pkg and the fenwick_tree_order_statistic RTL.
module tb_fenwick_tree_order_statistic
    import fwt_pkg::*;
();

    localparam logic [2:0] OP_FIRST_UNUSED = OP_FIND + 3'd1;
    localparam int unsigned QUIET_LIMIT = 20000;
    localparam int unsigned HOLD_AT     = 150;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned PHASE_WORDS = 125;

    typedef struct {
        logic [2:0]  opcode;
        logic [10:0] index_a;
        logic [10:0] index_b;
        logic [31:0] operand;
    } tree_word_t;

    typedef struct {
        logic [31:0] sum;
        logic [10:0] found;
        logic        done;
    } tree_answer_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;

    fenwick_tree_order_statistic u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    tree_word_t   word_queue[$];
    tree_answer_t expected_answers[$];
    tree_word_t   offered_word;
    logic [31:0]  fen_nodes [0:MAX_ELEMENTS-1];
    logic [10:0]  tracked_size = 11'd1024;
    int unsigned  words_queued   = 0;
    int unsigned  words_accepted = 0;
    int unsigned  answers_seen   = 0;
    int unsigned  hold_left      = 0;
    int unsigned  quiet_cycles   = 0;
    int unsigned  errors         = 0;
    bit           steady         = 1'b0;

    function automatic logic [31:0] prefix_total(int unsigned n, int unsigned sz);
        logic [31:0] acc;
        acc = '0;
        if (n > sz) n = sz;
        while (n > 0) begin
            acc += fen_nodes[n-1];
            n &= n - 1;
        end
        return acc;
    endfunction

    function automatic int unsigned count_within_limit(logic signed [31:0] limit,
                                                       int unsigned sz);
        int unsigned span, at;
        logic signed [31:0] acc, t;
        if (sz == 0) return 0;
        span = 1;
        while ((span << 1) <= sz) span <<= 1;
        at = 0;
        acc = '0;
        for (; span > 0; span >>= 1) begin
            if (at + span <= sz) begin
                t = acc + fen_nodes[at+span-1];
                if (!(limit < t)) begin
                    acc = t;
                    at += span;
                end
            end
        end
        return at;
    endfunction

    function automatic tree_answer_t apply_word(tree_word_t w);
        tree_answer_t r;
        int unsigned sz, i, j;
        sz = (tracked_size > MAX_ELEMENTS) ? MAX_ELEMENTS : tracked_size;
        r.sum = '0;
        r.found = '0;
        r.done = 1'b1;
        case (w.opcode)
            OP_FILL: begin
                for (i = 0; i < sz; i++) fen_nodes[i] = w.operand;
                for (i = 0; i < sz; i++) begin
                    j = i | (i + 1);
                    if (j < sz) fen_nodes[j] += fen_nodes[i];
                end
            end
            OP_ADD: begin
                for (i = w.index_a; i < sz; i = i | (i + 1)) fen_nodes[i] += w.operand;
            end
            OP_PSUM: r.sum = prefix_total(w.index_a, sz);
            OP_RSUM: r.sum = prefix_total(w.index_b, sz) - prefix_total(w.index_a, sz);
            OP_FIND: r.found = 11'(count_within_limit(w.operand, sz));
            default: r.done = 1'b0;
        endcase
        return r;
    endfunction

    // Sender side: offers queued words and predicts the answer of each accepted one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tracked_size = 11'd1024;
            for (int k = 0; k < MAX_ELEMENTS; k++) fen_nodes[k] = '0;
        end else begin
            if (cfg_valid && cfg_ready) tracked_size = cfg_data;
            if (s_tvalid && s_tready) begin
                expected_answers.insert(expected_answers.size(), apply_word(offered_word));
                words_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (word_queue.size() != 0 && (steady || $urandom_range(99) >= 12)) begin
                    offered_word = word_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, offered_word.operand, offered_word.index_b,
                                 offered_word.index_a};
                    s_tuser  <= offered_word.opcode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver side: random back-pressure, one long hold-off, and answer checking.
    always @(posedge aclk) begin
        tree_answer_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                answers_seen++;
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected word, sum_result %0d found_count %0d op_done %0d",
                             $time, $signed(m_tdata[31:0]), m_tdata[42:32], m_tuser[0]);
                    errors++;
                end else begin
                    want = expected_answers.pop_front();
                    if (m_tdata[31:0] !== want.sum) begin
                        $display("%0t: sum_result expected %0d, got %0d", $time,
                                 $signed(want.sum), $signed(m_tdata[31:0]));
                        errors++;
                    end
                    if (m_tdata[42:32] !== want.found) begin
                        $display("%0t: found_count expected %0d, got %0d", $time,
                                 want.found, m_tdata[42:32]);
                        errors++;
                    end
                    if (m_tuser[0] !== want.done) begin
                        $display("%0t: op_done expected %0d, got %0d", $time,
                                 want.done, m_tuser[0]);
                        errors++;
                    end
                end
                if (answers_seen == HOLD_AT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 12);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("tb_fenwick_tree_order_statistic: errors");
        $finish;
    end

    task automatic push_word(logic [2:0] op, logic [10:0] a, logic [10:0] b, logic [31:0] v);
        tree_word_t w;
        w.opcode = op;
        w.index_a = a;
        w.index_b = b;
        w.operand = v;
        word_queue.insert(word_queue.size(), w);
        words_queued++;
    endtask

    task automatic queue_random(int unsigned n, int unsigned size_raw);
        int unsigned sz, pick;
        logic [2:0] op;
        logic [10:0] a, b;
        logic [31:0] v;
        sz = (size_raw > MAX_ELEMENTS) ? MAX_ELEMENTS : size_raw;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 3) op = OP_FILL;
            else if (pick < 38) op = OP_ADD;
            else if (pick < 58) op = OP_PSUM;
            else if (pick < 78) op = OP_RSUM;
            else if (pick < 95) op = OP_FIND;
            else op = OP_FIRST_UNUSED + 3'($urandom_range(2));
            a = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(sz));
            b = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(sz));
            if ($urandom_range(4) == 0)
                v = $urandom;
            else if (op == OP_FILL)
                v = 32'($urandom_range(40)) - 32'd20;
            else if (op == OP_FIND)
                v = 32'($urandom_range(40 * sz + 100)) - 32'd100;
            else
                v = 32'($urandom_range(200)) - 32'd100;
            push_word(op, a, b, v);
        end
    endtask

    task automatic wait_idle();
        while (words_accepted != words_queued || answers_seen != words_accepted ||
               expected_answers.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_size(logic [10:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned phase_sizes[10];
        phase_sizes = '{1, 2047, 0, 2, 1024, 5, 1000, 1023, 512, 0};
        phase_sizes[9] = $urandom_range(1023, 3);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        push_word(OP_FIND, 11'd0, 11'd0, 32'd0);
        push_word(OP_PSUM, 11'd1024, 11'd0, 32'd0);
        push_word(OP_FILL, 11'd0, 11'd0, 32'h7FFF_FFFF);
        push_word(OP_PSUM, 11'd1024, 11'd0, 32'd0);
        push_word(OP_PSUM, 11'd0, 11'd0, 32'd0);
        push_word(OP_PSUM, 11'd2047, 11'd0, 32'd0);
        push_word(OP_RSUM, 11'd5, 11'd1000, 32'd0);
        push_word(OP_RSUM, 11'd1000, 11'd5, 32'd0);
        push_word(OP_RSUM, 11'd2047, 11'd0, 32'd0);
        push_word(OP_RSUM, 11'd0, 11'd2047, 32'd0);
        push_word(OP_ADD, 11'd0, 11'd0, 32'h8000_0000);
        push_word(OP_ADD, 11'd1023, 11'd0, 32'hFFFF_FFFF);
        push_word(OP_ADD, 11'd1024, 11'd0, 32'd5);
        push_word(OP_ADD, 11'd2047, 11'd0, 32'h7FFF_FFFF);
        push_word(OP_PSUM, 11'd1, 11'd0, 32'd0);
        push_word(OP_PSUM, 11'd1023, 11'd0, 32'd0);
        push_word(OP_FIND, 11'd0, 11'd0, 32'h7FFF_FFFF);
        push_word(OP_FIND, 11'd0, 11'd0, 32'h8000_0000);
        push_word(OP_FIND, 11'd0, 11'd0, 32'hFFFF_FFFF);
        push_word(OP_FIND, 11'd0, 11'd0, 32'd0);
        for (int k = 0; k < 3; k++)
            push_word(OP_FIRST_UNUSED + 3'(k), 11'h7FF, 11'h7FF, 32'hFFFF_FFFF);
        push_word(OP_FILL, 11'd0, 11'd0, 32'd1);
        push_word(OP_FIND, 11'd0, 11'd0, 32'd100);
        wait_idle();

        foreach (phase_sizes[p]) begin
            write_size(11'(phase_sizes[p]));
            steady = (p == 4);
            queue_random(PHASE_WORDS, phase_sizes[p]);
            wait_idle();
        end
        steady = 1'b0;

        repeat (40) @(posedge aclk);
        if (errors == 0)
            $display("tb_fenwick_tree_order_statistic: clean");
        else
            $display("tb_fenwick_tree_order_statistic: errors");
        $finish;
    end

endmodule

FILE: fenwick_tree_order_statistic.f
hw/rtl/fwt_pkg.sv
hw/rtl/fwt_ram.sv
hw/rtl/fwt_alu.sv
hw/rtl/fenwick_tree_order_statistic.sv
test/tb_fenwick_tree_order_statistic.sv
